[rtl/core/dtbsi_pkg.sv]
package dtbsi_pkg;

   localparam int OUT_WIDTH_DEFAULT = 32;
   localparam int EXP_WIDTH = 11;
   localparam int FRAC_WIDTH = 52;
   localparam int MANT_WIDTH = 53;
   localparam int FBITS_WIDTH = 5;
   localparam int SHIFT_WIDTH = 14;   // signed shift amount k

   localparam logic [EXP_WIDTH-1:0] EXP_SPECIAL = 11'h7FF;
   localparam logic [EXP_WIDTH-1:0] REF_EXP_RESET = 11'd1023;
   localparam logic [FBITS_WIDTH-1:0] FBITS_RESET = 5'd15;

   localparam logic CSR_REF_EXP = 1'b0;
   localparam logic CSR_FBITS = 1'b1;

   // classification from stage 1
   typedef enum logic [1:0] {
      CLS_ZERO,
      CLS_NAN,
      CLS_SAT,
      CLS_NUM
   } cls_type;

endpackage

[rtl/core/dtbsi_shift.sv]
// Stage 2: right-shift/left-shift of the mantissa into a 64-bit magnitude,
// overflow detect. Registered output.
module dtbsi_shift (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  dtbsi_pkg::cls_type                    in_cls,
   input  logic                                  in_neg,
   input  logic                                  in_last,
   input  logic [dtbsi_pkg::MANT_WIDTH-1:0]      in_mant,
   input  logic signed [dtbsi_pkg::SHIFT_WIDTH-1:0] in_k,
   output logic                                  out_valid,
   output dtbsi_pkg::cls_type                    out_cls,
   output logic                                  out_neg,
   output logic                                  out_last,
   output logic [63:0]                           out_mag
);
   logic                      valid_ff;
   dtbsi_pkg::cls_type        cls_ff, cls_in;
   logic                      neg_ff, last_ff;
   logic [63:0]               mag_ff, mag_in;
   logic [63:0]               mant_ext;

   assign mant_ext = {{(64-dtbsi_pkg::MANT_WIDTH){1'b0}}, in_mant};

   always_comb begin
      cls_in = in_cls;
      mag_in = '0;
      if (in_cls == dtbsi_pkg::CLS_NUM) begin
         if (in_k >= 0) begin
            // k >= 32 is classed as saturation without a check of the mantissa
            if (in_k >= 14'sd32) begin
               cls_in = dtbsi_pkg::CLS_SAT;
            end else begin
               // mant < 2^53 and k <= 31: fits in 84 bits; check high part
               if ((mant_ext >> (6'd32 - 6'(in_k))) != 64'd0) begin
                  cls_in = dtbsi_pkg::CLS_SAT;
               end else begin
                  mag_in = mant_ext << in_k[4:0];
               end
            end
         end else if (in_k <= -14'sd64) begin
            mag_in = '0;
         end else begin
            mag_in = mant_ext >> 6'(-in_k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      cls_ff  <= cls_in;
      neg_ff  <= in_neg;
      last_ff <= in_last;
      mag_ff  <= mag_in;
   end

   assign out_valid = valid_ff;
   assign out_cls   = cls_ff;
   assign out_neg   = neg_ff;
   assign out_last  = last_ff;
   assign out_mag   = mag_ff;
endmodule

[rtl/core/double_to_block_scaled_int.sv]
// double_to_block_scaled_int
// Converts one IEEE-754 double word per cycle into a signed integer equal to
// the sample times 2^m, truncated toward zero, m = fraction_bits -
// (reference_exponent_field - 1022) - 1.
// Input channel: req_start with req_sample_bits/req_last_in; a word is taken
// at each edge with req_start high and req_busy low. req_busy is always low:
// the pipeline never stalls.
// Result channel: rsp_valid strobes one cycle with rsp_fixed_value,
// rsp_range_flag, rsp_last_out. The receiver cannot stall.
// Pipeline: decode, shift and saturate stages, each registered; a word taken
// at an edge is strobed once it has passed the saturate stage register.
// Throughput: one word per cycle, every stage takes a new word each cycle.
// Saturation outside the signed OUT_WIDTH range and NaN raise range_flag;
// NaN gives zero. Values are sign-extended to 32 bits.
// Configuration: csr_valid/csr_ready write channel, csr_ready always high;
// index 0 = reference exponent field, 1 = fraction bits. Write only idle.
// Reset (synchronous): pipeline emptied, registers to 1023 and 15.
module double_to_block_scaled_int #(
   parameter int OUT_WIDTH = dtbsi_pkg::OUT_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               req_busy,
   input  logic [63:0]        req_sample_bits,
   input  logic               req_last_in,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_fixed_value,
   output logic               rsp_range_flag,
   output logic               rsp_last_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_data
);
   localparam logic [63:0] LIM = 64'd1 << (OUT_WIDTH - 1);

   logic [dtbsi_pkg::EXP_WIDTH-1:0]   ref_exp_ff;
   logic [dtbsi_pkg::FBITS_WIDTH-1:0] fbits_ff;

   assign req_busy  = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_exp_ff <= dtbsi_pkg::REF_EXP_RESET;
         fbits_ff   <= dtbsi_pkg::FBITS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            dtbsi_pkg::CSR_REF_EXP: ref_exp_ff <= csr_data[dtbsi_pkg::EXP_WIDTH-1:0];
            dtbsi_pkg::CSR_FBITS:   fbits_ff <= csr_data[dtbsi_pkg::FBITS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: decode and compute k = e - 1075 + m
   logic [dtbsi_pkg::EXP_WIDTH-1:0]  expf;
   logic [dtbsi_pkg::FRAC_WIDTH-1:0] frac;
   logic signed [dtbsi_pkg::SHIFT_WIDTH-1:0] k_in, m_val;
   dtbsi_pkg::cls_type cls_in;
   logic [dtbsi_pkg::MANT_WIDTH-1:0] mant_in;

   assign expf = req_sample_bits[62:52];
   assign frac = req_sample_bits[51:0];
   assign m_val = $signed({9'd0, fbits_ff}) - $signed({3'd0, ref_exp_ff}) + 14'sd1021;

   always_comb begin
      mant_in = {(expf != '0), frac};
      k_in = $signed({3'd0, (expf == '0) ? 11'd1 : expf}) - 14'sd1075 + m_val;
      if (expf == dtbsi_pkg::EXP_SPECIAL) begin
         cls_in = (frac != '0) ? dtbsi_pkg::CLS_NAN : dtbsi_pkg::CLS_SAT;
      end else if (mant_in == '0) begin
         cls_in = dtbsi_pkg::CLS_ZERO;
      end else begin
         cls_in = dtbsi_pkg::CLS_NUM;
      end
   end

   logic v1_ff, neg1_ff, last1_ff;
   dtbsi_pkg::cls_type cls1_ff;
   logic [dtbsi_pkg::MANT_WIDTH-1:0] mant1_ff;
   logic signed [dtbsi_pkg::SHIFT_WIDTH-1:0] k1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= req_start;
      end
      neg1_ff  <= req_sample_bits[63];
      last1_ff <= req_last_in;
      cls1_ff  <= cls_in;
      mant1_ff <= mant_in;
      k1_ff    <= k_in;
   end

   // stage 2: shift
   logic v2, neg2, last2;
   dtbsi_pkg::cls_type cls2;
   logic [63:0] mag2;

   dtbsi_shift u_shift (
      .clock(clock), .reset(reset),
      .in_valid(v1_ff), .in_cls(cls1_ff), .in_neg(neg1_ff), .in_last(last1_ff),
      .in_mant(mant1_ff), .in_k(k1_ff),
      .out_valid(v2), .out_cls(cls2), .out_neg(neg2), .out_last(last2),
      .out_mag(mag2)
   );

   // stage 3: saturate, negate
   logic [63:0] maxmag, mag_sel, val64;
   logic        flag_in, neg_sel;
   always_comb begin
      maxmag  = neg2 ? LIM : LIM - 64'd1;
      neg_sel = neg2;
      flag_in = 1'b0;
      mag_sel = mag2;
      case (cls2)
         dtbsi_pkg::CLS_ZERO: begin
            mag_sel = '0;
            neg_sel = 1'b0;
         end
         dtbsi_pkg::CLS_NAN: begin
            mag_sel = '0;
            neg_sel = 1'b0;
            flag_in = 1'b1;
         end
         dtbsi_pkg::CLS_SAT: begin
            mag_sel = maxmag;
            flag_in = 1'b1;
         end
         default: begin
            if (mag2 > maxmag) begin
               mag_sel = maxmag;
               flag_in = 1'b1;
            end
         end
      endcase
      val64 = neg_sel ? (64'd0 - mag_sel) : mag_sel;
   end

   logic v3_ff, flag3_ff, last3_ff;
   logic [31:0] val3_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2;
      end
      flag3_ff <= flag_in;
      last3_ff <= last2;
      val3_ff  <= val64[31:0];
   end

   assign rsp_valid       = v3_ff;
   assign rsp_fixed_value = $signed(val3_ff);
   assign rsp_range_flag  = flag3_ff;
   assign rsp_last_out    = last3_ff;
endmodule

[rtl/core/dtbsi_checker.sv]
module dtbsi_checker #(
   parameter int OUT_WIDTH = dtbsi_pkg::OUT_WIDTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   input logic        req_start,
   input logic        req_busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_fixed_value,
   input logic        rsp_range_flag
);
   // saturation bounds, sign-extended to 32 bits
   localparam logic [31:0] MAX_VAL = 32'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
   localparam logic [31:0] MIN_VAL = ~MAX_VAL;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_start && !req_busy) |-> ##3 rsp_valid) else $error("missing result");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_start && !req_busy, 3)) else $error("spurious result");
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !req_busy) else $error("busy raised");
   // flagged words are zero (NaN) or a saturation bound
   a_flag_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_flag) |-> (rsp_fixed_value == 32'h0 ||
      rsp_fixed_value == MAX_VAL || rsp_fixed_value == MIN_VAL))
      else $error("bad flagged value");
endmodule

bind double_to_block_scaled_int dtbsi_checker #(.OUT_WIDTH(OUT_WIDTH)) u_dtbsi_checker (
   .clock(clock), .reset(reset), .req_start(req_start), .req_busy(req_busy),
   .rsp_valid(rsp_valid), .rsp_fixed_value(rsp_fixed_value),
   .rsp_range_flag(rsp_range_flag)
);
